/* rtl/atan2pa_pkg.sv */
// ----------------------------------------------------------------------------
// atan2pa_pkg
// shared constants and types of the polynomial atan2 unit
// ----------------------------------------------------------------------------
package atan2pa_pkg;

	// ratio and polynomial argument, unsigned q0.16
	localparam int R_FRAC = 16;

	// odd minimax coefficients, q1.16 signed, highest power first
	localparam int COEF_W = 18;
	localparam int COEF_N = 6;
	localparam logic signed [COEF_W-1:0] COEF [COEF_N] = '{
		-18'sd883, 18'sd3767, -18'sd7946, 18'sd12821, -18'sd21823, 18'sd65536
	};

	// pi and pi/2 in q2.30
	localparam int          Q30_FRAC    = 30;
	localparam logic [63:0] PI_Q30      = 64'd3373259426;
	localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;

	// octant and quadrant fold information that travels with each item
	typedef struct packed {
		logic swap;   // |y| > |x|
		logic x_neg;
		logic y_neg;
		logic zero;   // both inputs zero
		logic sat;    // equal magnitudes, ratio saturates
	} fold_t;

endpackage

/* rtl/atan2_polynomial_approx_unit.sv */
// ----------------------------------------------------------------------------
// atan2_polynomial_approx_unit
// pipelined four-quadrant arctangent by odd minimax polynomial
// ----------------------------------------------------------------------------
// usage:
//   input channel s_*: one transaction carries one vector (vec_x, vec_y),
//   both two's complement at the same scale. output channel m_*: one
//   transaction carries the angle in radians as signed q3.ANGLE_FRAC_BITS
//   and a zero_vector flag in m_tuser.
// stages: 1 fold stage, 16 divider stages, square, argument round, 5 horner
//   stages, scale round, quadrant fold.
// throughput: one vector per cycle while the output side does not stall;
//   the depth is set by the restoring divider that retires one quotient
//   bit per stage.
// stall: the whole pipe advances on one enable; when m_tvalid is high and
//   m_tready is low every stage holds and s_tready drops in the same cycle,
//   so no transaction is lost or repeated. bubbles advance whenever the
//   output register is empty or being taken.
// reset: arst_n clears all stage valid bits at once; payload registers are
//   not reset. no result is presented until an input transaction has gone
//   through the pipe.
// zero vector: both inputs zero gives angle 0 and zero_vector 1.
// ----------------------------------------------------------------------------
module atan2_polynomial_approx_unit #(
	parameter int IN_WIDTH        = 16,
	parameter int ANGLE_FRAC_BITS = 13
) (
	input  logic                                      clk,
	input  logic                                      arst_n,
	input  logic                                      s_tvalid,
	output logic                                      s_tready,
	// vec_x, vec_y (low to high), zero padded to whole bytes
	input  logic [((2*IN_WIDTH+7)/8)*8-1:0]           s_tdata,
	output logic                                      m_tvalid,
	input  logic                                      m_tready,
	// angle, zero padded to whole bytes
	output logic [((ANGLE_FRAC_BITS+3+7)/8)*8-1:0]    m_tdata,
	// zero_vector
	output logic [0:0]                                m_tuser
);

	localparam int ANGLE_W    = ANGLE_FRAC_BITS + 3;
	localparam int OUT_DATA_W = ((ANGLE_W + 7) / 8) * 8;
	localparam int R_W        = atan2pa_pkg::R_FRAC;
	localparam int DIV_N      = R_W;
	localparam int P_W        = atan2pa_pkg::COEF_W;
	localparam int T_W        = R_W + 1;
	localparam int PROD_W     = P_W + T_W;
	localparam int H_N        = atan2pa_pkg::COEF_N - 1;
	localparam int A_SHIFT    = 2 * R_W - ANGLE_FRAC_BITS;
	localparam int FOLD_W     = ANGLE_W + 1;
	localparam int PI_SHIFT   = atan2pa_pkg::Q30_FRAC - ANGLE_FRAC_BITS;
	localparam logic [63:0] PI_F =
		(atan2pa_pkg::PI_Q30 + (64'd1 << (PI_SHIFT - 1))) >> PI_SHIFT;
	localparam logic [63:0] HALF_PI_F =
		(atan2pa_pkg::HALF_PI_Q30 + (64'd1 << (PI_SHIFT - 1))) >> PI_SHIFT;

	// round to nearest, ties away from zero, then arithmetic shift
	function automatic logic signed [PROD_W-1:0] rnd_shift(
		input logic signed [PROD_W-1:0] v,
		input int unsigned              s
	);
		logic signed [PROD_W-1:0] bias;
		bias = (PROD_W'(1) << (s - 1)) - $signed(PROD_W'(v[PROD_W-1]));
		return (v + bias) >>> s;
	endfunction

	// pipeline advance: output register empty or being taken
	logic en;
	assign en       = !m_tvalid || m_tready;
	assign s_tready = en;

	// ---------------- stage 1: magnitudes, min/max, fold flags -------------
	logic [IN_WIDTH-1:0] x_in, y_in, ax, ay;
	logic                swap;
	atan2pa_pkg::fold_t  fl_d;

	assign x_in = s_tdata[IN_WIDTH-1:0];
	assign y_in = s_tdata[2*IN_WIDTH-1:IN_WIDTH];
	// unsigned magnitude keeps the most negative input exact
	assign ax   = x_in[IN_WIDTH-1] ? IN_WIDTH'(-x_in) : x_in;
	assign ay   = y_in[IN_WIDTH-1] ? IN_WIDTH'(-y_in) : y_in;
	assign swap = ay > ax;

	always_comb begin
		fl_d.swap  = swap;
		fl_d.x_neg = x_in[IN_WIDTH-1];
		fl_d.y_neg = y_in[IN_WIDTH-1];
		fl_d.zero  = (ax == '0) && (ay == '0);
		fl_d.sat   = ax == ay;
	end

	logic                vld_s1;
	logic [IN_WIDTH-1:0] mx_s1, mn_s1;
	atan2pa_pkg::fold_t  fl_s1;

	always_ff @(posedge clk) begin
		if (en) begin
			mx_s1 <= swap ? ay : ax;
			mn_s1 <= swap ? ax : ay;
			fl_s1 <= fl_d;
		end
	end

	// ---------------- divider: one quotient bit per stage -------------------
	// remainder starts at min; for min below max it stays below max and quotient is floor(min*2^16/max)
	logic [IN_WIDTH-1:0] drem_s [DIV_N];
	logic [IN_WIDTH-1:0] dmx_s  [DIV_N];
	logic [R_W-1:0]      dquo_s [DIV_N];
	atan2pa_pkg::fold_t  dfl_s  [DIV_N];
	logic [DIV_N-1:0]    dvld_s;

	logic [IN_WIDTH-1:0] drem_d [DIV_N];
	logic [IN_WIDTH-1:0] dmx_d  [DIV_N];
	logic [R_W-1:0]      dquo_d [DIV_N];
	atan2pa_pkg::fold_t  dfl_d  [DIV_N];

	always_comb begin
		for (int k = 0; k < DIV_N; k++) begin
			logic [IN_WIDTH-1:0] rem_in;
			logic [R_W-1:0]      quo_in;
			logic [IN_WIDTH:0]   dbl;
			logic [IN_WIDTH:0]   diff;
			logic                ge;
			if (k == 0) begin
				rem_in   = mn_s1;
				quo_in   = '0;
				dmx_d[k] = mx_s1;
				dfl_d[k] = fl_s1;
			end else begin
				rem_in   = drem_s[k-1];
				quo_in   = dquo_s[k-1];
				dmx_d[k] = dmx_s[k-1];
				dfl_d[k] = dfl_s[k-1];
			end
			dbl       = {rem_in, 1'b0};
			diff      = dbl - {1'b0, dmx_d[k]};
			ge        = dbl >= {1'b0, dmx_d[k]};
			drem_d[k] = ge ? diff[IN_WIDTH-1:0] : dbl[IN_WIDTH-1:0];
			dquo_d[k] = {quo_in[R_W-2:0], ge};
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int k = 0; k < DIV_N; k++) begin
				drem_s[k] <= drem_d[k];
				dmx_s[k]  <= dmx_d[k];
				dquo_s[k] <= dquo_d[k];
				dfl_s[k]  <= dfl_d[k];
			end
		end
	end

	// ---------------- stage 2: saturate ratio, square -----------------------
	logic               vld_s2;
	logic [R_W-1:0]     r_d;
	logic [R_W-1:0]     r_s2;
	logic [2*R_W-1:0]   sq_s2;
	atan2pa_pkg::fold_t fl_s2;

	// equal magnitudes would give exactly 1.0, held at the largest q0.16 code
	assign r_d = dfl_s[DIV_N-1].sat ? '1 : dquo_s[DIV_N-1];

	always_ff @(posedge clk) begin
		if (en) begin
			r_s2  <= r_d;
			sq_s2 <= r_d * r_d;
			fl_s2 <= dfl_s[DIV_N-1];
		end
	end

	// ---------------- stage 3: round argument, first horner product ---------
	logic [2*R_W:0]           tsum;
	logic [R_W-1:0]           t_d;
	logic signed [T_W-1:0]    t_sx;
	logic signed [PROD_W-1:0] prod_d3;

	assign tsum    = {1'b0, sq_s2} + ((2*R_W+1)'(1) << (R_W - 1));
	assign t_d     = tsum[2*R_W-1:R_W];
	assign t_sx    = {1'b0, t_d};
	assign prod_d3 = atan2pa_pkg::COEF[0] * t_sx;

	logic                     vld_s3;
	logic [R_W-1:0]           t_s3, r_s3;
	logic signed [PROD_W-1:0] prod_s3;
	atan2pa_pkg::fold_t       fl_s3;

	always_ff @(posedge clk) begin
		if (en) begin
			t_s3    <= t_d;
			r_s3    <= r_s2;
			prod_s3 <= prod_d3;
			fl_s3   <= fl_s2;
		end
	end

	// ---------------- horner stages: p = round(prod) + c, then p * t -------
	// the last stage multiplies by the ratio instead of its square
	logic signed [PROD_W-1:0] hprod_s [H_N];
	logic [R_W-1:0]           ht_s    [H_N];
	logic [R_W-1:0]           hr_s    [H_N];
	atan2pa_pkg::fold_t       hfl_s   [H_N];
	logic [H_N-1:0]           hvld_s;

	logic signed [PROD_W-1:0] hprod_d [H_N];
	logic [R_W-1:0]           ht_d    [H_N];
	logic [R_W-1:0]           hr_d    [H_N];
	atan2pa_pkg::fold_t       hfl_d   [H_N];

	always_comb begin
		for (int j = 0; j < H_N; j++) begin
			logic signed [PROD_W-1:0] prod_in;
			logic signed [P_W-1:0]    p;
			logic signed [T_W-1:0]    opnd;
			if (j == 0) begin
				prod_in = prod_s3;
				ht_d[j] = t_s3;
				hr_d[j] = r_s3;
				hfl_d[j] = fl_s3;
			end else begin
				prod_in = hprod_s[j-1];
				ht_d[j] = ht_s[j-1];
				hr_d[j] = hr_s[j-1];
				hfl_d[j] = hfl_s[j-1];
			end
			p          = P_W'(rnd_shift(prod_in, R_W)) + atan2pa_pkg::COEF[j+1];
			opnd       = (j == H_N - 1) ? $signed({1'b0, hr_d[j]}) : $signed({1'b0, ht_d[j]});
			hprod_d[j] = p * opnd;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int j = 0; j < H_N; j++) begin
				hprod_s[j] <= hprod_d[j];
				ht_s[j]    <= ht_d[j];
				hr_s[j]    <= hr_d[j];
				hfl_s[j]   <= hfl_d[j];
			end
		end
	end

	// ---------------- stage 4: scale to q3.f --------------------------------
	logic                     vld_s4;
	logic signed [FOLD_W-1:0] a_s4;
	atan2pa_pkg::fold_t       fl_s4;

	always_ff @(posedge clk) begin
		if (en) begin
			a_s4  <= FOLD_W'(rnd_shift(hprod_s[H_N-1], A_SHIFT));
			fl_s4 <= hfl_s[H_N-1];
		end
	end

	// ---------------- stage 5: octant and quadrant folds, output register ---
	logic signed [FOLD_W-1:0] oct_a, quad_a, sign_a;

	assign oct_a  = fl_s4.swap  ? $signed(HALF_PI_F[FOLD_W-1:0]) - a_s4 : a_s4;
	assign quad_a = fl_s4.x_neg ? $signed(PI_F[FOLD_W-1:0]) - oct_a : oct_a;
	assign sign_a = fl_s4.y_neg ? -quad_a : quad_a;

	logic               vld_s5;
	logic [ANGLE_W-1:0] angle_s5;
	logic               zero_s5;

	always_ff @(posedge clk) begin
		if (en) begin
			angle_s5 <= fl_s4.zero ? '0 : sign_a[ANGLE_W-1:0];
			zero_s5  <= fl_s4.zero;
		end
	end

	// ---------------- valid bits --------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			dvld_s <= '0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			hvld_s <= '0;
			vld_s4 <= 1'b0;
			vld_s5 <= 1'b0;
		end else if (en) begin
			vld_s1 <= s_tvalid;
			dvld_s <= {dvld_s[DIV_N-2:0], vld_s1};
			vld_s2 <= dvld_s[DIV_N-1];
			vld_s3 <= vld_s2;
			hvld_s <= {hvld_s[H_N-2:0], vld_s3};
			vld_s4 <= hvld_s[H_N-1];
			vld_s5 <= vld_s4;
		end
	end

	assign m_tvalid = vld_s5;
	assign m_tdata  = OUT_DATA_W'(angle_s5);
	assign m_tuser  = zero_s5;

endmodule

/* rtl/atan2pa_chk.sv */
// ----------------------------------------------------------------------------
// atan2pa_chk
// port-level checks of the polynomial atan2 unit
// ----------------------------------------------------------------------------
module atan2pa_chk #(
	parameter int IN_WIDTH        = 16,
	parameter int ANGLE_FRAC_BITS = 13
) (
	input logic                                   clk,
	input logic                                   arst_n,
	input logic                                   s_tvalid,
	input logic                                   s_tready,
	input logic [((2*IN_WIDTH+7)/8)*8-1:0]        s_tdata,
	input logic                                   m_tvalid,
	input logic                                   m_tready,
	input logic [((ANGLE_FRAC_BITS+3+7)/8)*8-1:0] m_tdata,
	input logic [0:0]                             m_tuser
);

	localparam int ANGLE_W  = ANGLE_FRAC_BITS + 3;
	localparam int PI_SHIFT = atan2pa_pkg::Q30_FRAC - ANGLE_FRAC_BITS;
	localparam logic [63:0] PI_F =
		(atan2pa_pkg::PI_Q30 + (64'd1 << (PI_SHIFT - 1))) >> PI_SHIFT;
	localparam logic signed [ANGLE_W:0] PI_LIM = $signed({1'b0, PI_F[ANGLE_W-1:0]});

	logic signed [ANGLE_W:0] ang;
	assign ang = $signed({m_tdata[ANGLE_W-1], m_tdata[ANGLE_W-1:0]});

	// a stalled output transaction holds
	ap_stall_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
		else $error("output changed while stalled");

	// zero vector forces angle 0
	ap_zero_angle: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser[0] |-> m_tdata[ANGLE_W-1:0] == '0)
		else $error("zero vector with nonzero angle");

	// angle stays within minus pi to pi
	ap_range: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (ang <= PI_LIM) && (ang >= -PI_LIM))
		else $error("angle out of range");

	// input side follows the output register: full and stalled means no intake
	ap_ready: assert property (@(posedge clk) disable iff (!arst_n)
		s_tready == (!m_tvalid || m_tready))
		else $error("s_tready does not track output stall");

	// nothing presented while in reset
	ap_reset: assert property (@(posedge clk)
		!arst_n |-> !m_tvalid)
		else $error("m_tvalid during reset");

endmodule

bind atan2_polynomial_approx_unit atan2pa_chk #(
	.IN_WIDTH        (IN_WIDTH),
	.ANGLE_FRAC_BITS (ANGLE_FRAC_BITS)
) u_atan2pa_chk (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tvalid (s_tvalid),
	.s_tready (s_tready),
	.s_tdata  (s_tdata),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata),
	.m_tuser  (m_tuser)
);
